// ===== hw/rtl/prewitt_gradient_nms_unit_defines.svh =====
`ifndef PREWITT_GRADIENT_NMS_UNIT_DEFINES_SVH
`define PREWITT_GRADIENT_NMS_UNIT_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define PGN_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define PGN_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/pgn_pkg.sv =====
`default_nettype none

package pgn_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [7:0]  THR_RESET    = 8'd20;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;

  // Number of angle boundaries (index 0 unused by the search)
  localparam int NBOUND = 180;

  typedef struct packed {
    logic [7:0]  thr;
    logic [10:0] width;
    logic [10:0] height;
  } cfg_t;

  // One classified request handed from front to back
  typedef struct packed {
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic               grad_en;
    logic               report;
    logic               border;
    logic               last;
    logic [9:0]         row;
    logic [9:0]         col;
  } job_t;

  typedef logic signed [29:0] trig_rom_t [NBOUND];

  // Build Q28 sine or cosine of k degrees by truncated Taylor sums
  function automatic trig_rom_t build_trig(input logic want_cos);
    trig_rom_t          rom;
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    rom[0] = want_cos ? 30'sd268435456 : 30'sd0;
    for (int k = 1; k < NBOUND; k++) begin
      th = (64'(k) * 64'd10000 * 64'd268435456 + 64'd286478) / 64'd572957;
      x2 = (th * th) >> 28;
      if (want_cos) begin
        term = 64'd268435456;
        sum  = 64'sd268435456;
        for (int n = 1; n < 40; n++) begin
          term = ((term * x2) >> 28) / 64'((2 * n - 1) * (2 * n));
          sum  = (n % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
        end
      end else begin
        term = th;
        sum  = $signed(th);
        for (int n = 1; n < 40; n++) begin
          term = ((term * x2) >> 28) / 64'((2 * n) * (2 * n + 1));
          sum  = (n % 2 == 1) ? sum - $signed(term) : sum + $signed(term);
        end
      end
      rom[k] = sum[29:0];
    end
    return rom;
  endfunction

  localparam trig_rom_t COS_ROM = build_trig(1'b1);
  localparam trig_rom_t SIN_ROM = build_trig(1'b0);

endpackage

`default_nettype wire

// ===== hw/rtl/prewitt_gradient_nms_unit.sv =====
// Path: an accepted pixel is registered in the front end and pushed into the queue; the back
// end pops it, runs the square root and angle search, and commits it once the output is free.
// Throughput: the back end handles one pixel at a time (pop, 8-bit angle search bit by bit,
// commit) and pops the next only after the commit; the front end takes one pixel per cycle
// into a four-entry queue until it fills.
// Reset: synchronous rst restores the registers to 20/640/480 and clears position, windows
// and queue; line stores are not cleared.
`default_nettype none
`include "prewitt_gradient_nms_unit_defines.svh"

module prewitt_gradient_nms_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  edge_value,
  output logic [7:0]  gradient_half,
  output logic [7:0]  angle_deg,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        frame_last
);
  import pgn_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(job_t) + AW;

  cfg_t          cfg;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  job_t          f_job;
  logic [AW-1:0] f_idx;
  logic [QW-1:0] q_dout;
  job_t          b_job;
  logic [AW-1:0] b_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr    <= THR_RESET;
      cfg.width  <= WIDTH_RESET;
      cfg.height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg.thr    <= cfg_data[7:0];
        CFG_WIDTH:     cfg.width  <= cfg_data;
        CFG_HEIGHT:    cfg.height <= cfg_data;
        default:       ;
      endcase
    end
  end

  pgn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel(pixel), .frame_start(frame_start),
    .q_full(q_full), .q_push(q_push), .q_job(f_job), .q_idx(f_idx)
  );

  pgn_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .din({f_job, f_idx}), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  assign b_job = q_dout[QW-1:AW];
  assign b_idx = q_dout[AW-1:0];

  pgn_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk(clk), .rst(rst), .thr(cfg.thr),
    .q_empty(q_empty), .q_pop(q_pop), .q_job(b_job), .q_idx(b_idx),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_value(edge_value), .gradient_half(gradient_half),
    .angle_deg(angle_deg), .out_row(out_row), .out_col(out_col),
    .frame_last(frame_last)
  );

  // Queue never overruns or underruns
  `PGN_ASSERT_NOW(a_no_overrun, q_push && q_full, q_pop, "push into full queue")
  `PGN_ASSERT_NOW(a_no_underrun, q_pop, !q_empty, "pop from empty queue")
  `PGN_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed request lost")
  // A kept edge carries the halved magnitude itself
  `PGN_ASSERT_NOW(a_edge_value, out_valid && edge_value != 8'd0,
                  edge_value == gradient_half && angle_deg <= 8'd179, "bad edge value")

endmodule

`default_nettype wire

// ===== hw/rtl/pgn_ram.sv =====
`default_nettype none

module pgn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgn_queue.sv =====
`default_nettype none

module pgn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  import pgn_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [WIDTH-1:0] slot [QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  assign full  = (count == (PW + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slot[rptr];

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pgn_front.sv =====
`default_nettype none

module pgn_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pgn_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   pixel,
  input  logic                         frame_start,
  input  logic                         q_full,
  output logic                         q_push,
  output pgn_pkg::job_t                q_job,
  output logic [$clog2(MAX_WIDTH)-1:0] q_idx
);
  import pgn_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int LIM = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [10:0] LIM_W = 11'(LIM);

  logic [10:0]   w_eff;
  logic [10:0]   h_eff;
  logic [9:0]    row;
  logic [9:0]    col;
  logic [AW-1:0] idx;
  logic [9:0]    r_cur;
  logic [9:0]    c_cur;
  logic [AW-1:0] i_cur;
  logic [10:0]   c_inc;
  logic [10:0]   r_inc;
  logic [9:0]    row_next;
  logic [9:0]    col_next;
  logic [AW-1:0] idx_next;
  logic          accept;
  logic          s1_valid;
  logic          s1_adv;
  logic [7:0]    s1_pix;
  logic [AW-1:0] s1_idx;
  job_t          s1_job;
  job_t          info;
  logic          fwd;
  logic [7:0]    fwd0;
  logic [7:0]    fwd1;
  logic [7:0]    rd0;
  logic [7:0]    rd1;
  logic [7:0]    line0;
  logic [7:0]    line1;
  logic [7:0]    pw [3][3];
  logic [7:0]    nw [3][3];
  logic [9:0]    sum_c0;
  logic [9:0]    sum_c2;
  logic [9:0]    sum_r0;
  logic [9:0]    sum_r2;

  // Clamp frame size
  always_comb begin
    if (cfg.width < 11'd5) w_eff = 11'd5;
    else if (cfg.width > LIM_W) w_eff = LIM_W;
    else w_eff = cfg.width;
    if (cfg.height < 11'd5) h_eff = 11'd5;
    else if (cfg.height > 11'd1024) h_eff = 11'd1024;
    else h_eff = cfg.height;
  end

  assign s1_adv   = s1_valid && !q_full;
  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;

  // Position of this pixel, restarted by frame_start
  assign r_cur = frame_start ? '0 : row;
  assign c_cur = frame_start ? '0 : col;
  assign i_cur = frame_start ? '0 : idx;

  // Advance raster position
  always_comb begin
    c_inc    = {1'b0, c_cur} + 11'd1;
    r_inc    = {1'b0, r_cur} + 11'd1;
    row_next = r_cur;
    col_next = c_inc[9:0];
    idx_next = (i_cur == AW'(MAX_WIDTH - 1)) ? '0 : i_cur + 1'b1;
    if (c_inc >= w_eff) begin
      col_next = '0;
      idx_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[9:0];
    end
  end

  // Classify the pixel
  always_comb begin
    info         = '0;
    info.grad_en = (r_cur >= 10'd2) && (c_cur >= 10'd2);
    info.report  = (r_cur >= 10'd3) && (c_cur >= 10'd3);
    info.border  = (r_cur == 10'd3) || (c_cur == 10'd3) ||
                   ({1'b0, r_cur} >= h_eff) || ({1'b0, c_cur} >= w_eff);
    info.last    = ({1'b0, r_cur} == h_eff - 11'd1) && ({1'b0, c_cur} == w_eff - 11'd1);
    info.row     = r_cur - 10'd3;
    info.col     = c_cur - 10'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      idx <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
      idx <= idx_next;
    end
  end

  // Hold the accepted pixel until it moves into the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (accept) fwd <= s1_adv && (s1_idx == i_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel;
      s1_idx <= i_cur;
      s1_job <= info;
      fwd0   <= s1_pix;
      fwd1   <= line0;
    end
  end

  // Line stores: line0 holds the row above, line1 two rows above
  pgn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk(clk), .we(s1_adv), .waddr(s1_idx), .wdata(s1_pix),
    .re(accept), .raddr(i_cur), .rdata(rd0)
  );

  pgn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk(clk), .we(s1_adv), .waddr(s1_idx), .wdata(line0),
    .re(accept), .raddr(i_cur), .rdata(rd1)
  );

  // Bypass a write to the same column made as the read went out
  assign line0 = fwd ? fwd0 : rd0;
  assign line1 = fwd ? fwd1 : rd1;

  // Shift the window by one column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = pw[i][1];
      nw[i][1] = pw[i][2];
    end
    nw[0][2] = line1;
    nw[1][2] = line0;
    nw[2][2] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pw[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      pw <= nw;
    end
  end

  // Prewitt sums
  always_comb begin
    sum_c0 = 10'(nw[0][0]) + 10'(nw[1][0]) + 10'(nw[2][0]);
    sum_c2 = 10'(nw[0][2]) + 10'(nw[1][2]) + 10'(nw[2][2]);
    sum_r0 = 10'(nw[0][0]) + 10'(nw[0][1]) + 10'(nw[0][2]);
    sum_r2 = 10'(nw[2][0]) + 10'(nw[2][1]) + 10'(nw[2][2]);
  end

  always_comb begin
    q_job    = s1_job;
    q_job.dx = $signed({1'b0, sum_c2}) - $signed({1'b0, sum_c0});
    q_job.dy = $signed({1'b0, sum_r2}) - $signed({1'b0, sum_r0});
  end

  assign q_push = s1_adv;
  assign q_idx  = s1_idx;

endmodule

`default_nettype wire

// ===== hw/rtl/pgn_back.sv =====
`default_nettype none

module pgn_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   thr,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  pgn_pkg::job_t                q_job,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_idx,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   edge_value,
  output logic [7:0]                   gradient_half,
  output logic [7:0]                   angle_deg,
  output logic [9:0]                   out_row,
  output logic [9:0]                   out_col,
  output logic                         frame_last
);
  import pgn_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state;
  job_t               b_job;
  logic [AW-1:0]      b_idx;
  logic signed [21:0] pxx;
  logic signed [21:0] pyy;
  logic signed [21:0] m2_sum;
  logic [20:0]        m2;
  logic [20:0]        sq_v;
  logic [20:0]        sq_r;
  logic [20:0]        sq_b;
  logic [20:0]        sq_rb;
  logic [7:0]         k_acc;
  logic [2:0]         bitpos;
  logic               phase;
  logic [7:0]         cand;
  logic               cand_ok_c;
  logic [7:0]         rom_ix;
  logic               cand_ok;
  logic signed [29:0] rc;
  logic signed [29:0] rs;
  logic signed [40:0] pc;
  logic signed [40:0] ps;
  logic signed [41:0] e_val;
  logic               dy_neg;
  logic               pop;
  logic               commit;
  logic [15:0]        thr_sq;
  logic               big;
  logic [9:0]         half;
  logic [7:0]         g;
  logic [7:0]         a;
  logic [7:0]         g0rd;
  logic [7:0]         g1rd;
  logic [7:0]         ard;
  logic [7:0]         gw [3][3];
  logic [7:0]         ng [3][3];
  logic [7:0]         gv;
  logic [7:0]         n0;
  logic [7:0]         n1;
  logic [7:0]         centre;
  logic [7:0]         edge_c;
  logic [7:0]         angle_hold;

  assign pop    = (state == ST_IDLE) && !q_empty;
  assign q_pop  = pop;
  assign commit = (state == ST_DONE) && (!out_valid || out_ready);
  assign dy_neg = b_job.dy[10];

  // Squared magnitude of the popped request
  always_comb begin
    pxx    = 22'(q_job.dx) * 22'(q_job.dx);
    pyy    = 22'(q_job.dy) * 22'(q_job.dy);
    m2_sum = pxx + pyy;
  end

  // Next boundary to test in the angle search
  always_comb begin
    cand      = k_acc | (8'd1 << bitpos);
    cand_ok_c = (cand <= 8'd179);
    if (!cand_ok_c) rom_ix = '0;
    else if (dy_neg) rom_ix = 8'(NBOUND) - cand;
    else rom_ix = cand;
  end

  // Cross product against the boundary direction
  always_comb begin
    pc    = 41'(b_job.dy) * 41'(rc);
    ps    = 41'(b_job.dx) * 41'(rs);
    e_val = dy_neg ? 42'(pc) + 42'(ps) : 42'(pc) - 42'(ps);
  end

  assign sq_rb = sq_r + sq_b;

  // Sequencer: pop, iterate square root and angle search, commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (pop) state <= ST_RUN;
        ST_RUN:  if (phase && bitpos == 3'd0) state <= ST_DONE;
        ST_DONE: if (commit) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_job  <= q_job;
      b_idx  <= q_idx;
      m2     <= m2_sum[20:0];
      sq_v   <= m2_sum[20:0];
      sq_r   <= '0;
      sq_b   <= 21'd1 << 20;
      k_acc  <= '0;
      bitpos <= 3'd7;
      phase  <= 1'b0;
    end else if (state == ST_RUN) begin
      // One square-root digit per cycle
      if (sq_b != '0) begin
        if (sq_v >= sq_rb) begin
          sq_v <= sq_v - sq_rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      // Each angle bit: fetch the boundary, then test it
      if (!phase) begin
        rc      <= COS_ROM[rom_ix];
        rs      <= SIN_ROM[rom_ix];
        cand_ok <= cand_ok_c;
        phase   <= 1'b1;
      end else begin
        if (cand_ok && !e_val[41]) k_acc <= cand;
        phase <= 1'b0;
        if (bitpos != 3'd0) bitpos <= bitpos - 3'd1;
      end
    end
  end

  // Threshold, halve and saturate
  always_comb begin
    thr_sq = 16'(thr) * 16'(thr);
    big    = b_job.grad_en && (m2 >= {5'd0, thr_sq});
    half   = sq_r[10:1];
    if (!big) g = '0;
    else if (half > 10'd255) g = 8'd255;
    else g = half[7:0];
    a = (big && (b_job.dx != '0 || b_job.dy != '0)) ? k_acc : '0;
  end

  // Gradient and angle line stores
  pgn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_grad0 (
    .clk(clk), .we(commit), .waddr(b_idx), .wdata(g),
    .re(pop), .raddr(q_idx), .rdata(g0rd)
  );

  pgn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_grad1 (
    .clk(clk), .we(commit), .waddr(b_idx), .wdata(g0rd),
    .re(pop), .raddr(q_idx), .rdata(g1rd)
  );

  pgn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_angle (
    .clk(clk), .we(commit), .waddr(b_idx), .wdata(a),
    .re(pop), .raddr(q_idx), .rdata(ard)
  );

  // Shift the gradient window by one column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ng[i][0] = gw[i][1];
      ng[i][1] = gw[i][2];
    end
    ng[0][2] = g1rd;
    ng[1][2] = g0rd;
    ng[2][2] = g;
  end

  // Pick neighbors along the gradient sector and suppress
  always_comb begin
    gv     = ng[1][1];
    centre = angle_hold;
    priority if (centre <= 8'd22 || centre >= 8'd158) begin
      n0 = ng[1][2];
      n1 = ng[1][0];
    end else if (centre <= 8'd67) begin
      n0 = ng[2][0];
      n1 = ng[0][2];
    end else if (centre <= 8'd112) begin
      n0 = ng[2][1];
      n1 = ng[0][1];
    end else begin
      n0 = ng[0][0];
      n1 = ng[2][2];
    end
    edge_c = (!b_job.border && gv >= thr && gv >= n0 && gv >= n1) ? gv : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_hold <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          gw[i][j] <= '0;
        end
      end
    end else if (commit) begin
      gw         <= ng;
      angle_hold <= ard;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && b_job.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && b_job.report) begin
      edge_value    <= edge_c;
      gradient_half <= gv;
      angle_deg     <= centre;
      out_row       <= b_job.row;
      out_col       <= b_job.col;
      frame_last    <= b_job.last;
    end
  end

endmodule

`default_nettype wire

// ===== sim/prewitt_gradient_nms_unit_tb.sv =====
`timescale 1ns / 1ps

module prewitt_gradient_nms_unit_tb;
  import pgn_pkg::*;

  typedef struct {
    logic [7:0] pix;
    logic       fs;
  } pixel_req_t;

  typedef struct {
    logic [7:0] edge_v;
    logic [7:0] half;
    logic [7:0] ang;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } edge_res_t;

  localparam int MAXW = 1024;
  localparam int NB = 180;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  edge_value;
  logic [7:0]  gradient_half;
  logic [7:0]  angle_deg;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        frame_last;

  prewitt_gradient_nms_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel(pixel), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_value(edge_value), .gradient_half(gradient_half), .angle_deg(angle_deg),
    .out_row(out_row), .out_col(out_col), .frame_last(frame_last)
  );

  // Predictor state
  longint      cos_tab[NB];
  longint      sin_tab[NB];
  int          p_thr, p_width, p_height;
  logic [7:0]  pix_line[2][MAXW];
  logic [7:0]  grad_line[2][MAXW];
  logic [7:0]  ang_line[MAXW];
  logic [7:0]  pix_win[3][3];
  logic [7:0]  grad_win[3][3];
  int          pos_row, pos_col;
  logic [7:0]  ang_delay;

  pixel_req_t  pixel_q[$];
  edge_res_t   edge_q[$];
  int          errors;
  int          pixels_sent;
  int          edges_seen;
  int          phases_run;
  bit          quiet;
  bit          hold_req;

  // Q28 sine and cosine by truncated Taylor sums
  task automatic build_tables();
    longint unsigned th, x2, term;
    longint          sum;
    cos_tab[0] = longint'(1) << 28;
    sin_tab[0] = 0;
    for (int k = 1; k < NB; k++) begin
      th = (longint'(k) * 10000 * (longint'(1) << 28) + 286478) / 572957;
      x2 = (th * th) >> 28;
      term = th;
      sum = th;
      for (int n = 1; n < 40; n++) begin
        term = ((term * x2) >> 28) / ((2 * n) * (2 * n + 1));
        sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      sin_tab[k] = sum;
      term = longint'(1) << 28;
      sum = term;
      for (int n = 1; n < 40; n++) begin
        term = ((term * x2) >> 28) / ((2 * n - 1) * (2 * n));
        sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      cos_tab[k] = sum;
    end
  endtask

  function automatic int int_sqrt(input int unsigned v);
    int unsigned r, b;
    r = 0;
    b = 1 << 20;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Count angle boundaries at or below the gradient direction
  function automatic int grad_angle(input int dx, input int dy);
    int     cnt;
    longint e;
    cnt = 0;
    if (dx == 0 && dy == 0) return 0;
    for (int k = 1; k < NB; k++) begin
      if (dy >= 0) e = longint'(dy) * cos_tab[k] - longint'(dx) * sin_tab[k];
      else e = longint'(dy) * cos_tab[NB - k] + longint'(dx) * sin_tab[NB - k];
      if (e >= 0) cnt++;
    end
    return cnt;
  endfunction

  // Advance the predictor by one pixel and queue any edge it reports
  task automatic predict_pixel(input logic [7:0] pix, input logic fs);
    int        w, h, r, c, idx, g, a, dx, dy, m2, half, gv, n0, n1, ca;
    logic [7:0] old_a;
    edge_res_t res;
    w = (p_width < 5) ? 5 : (p_width > MAXW ? MAXW : p_width);
    h = (p_height < 5) ? 5 : (p_height > 1024 ? 1024 : p_height);
    r = pos_row;
    c = pos_col;
    g = 0;
    a = 0;
    if (fs) begin
      r = 0;
      c = 0;
    end
    idx = c % MAXW;
    // shift pixel window
    for (int i = 0; i < 3; i++) begin
      pix_win[i][0] = pix_win[i][1];
      pix_win[i][1] = pix_win[i][2];
    end
    pix_win[0][2] = pix_line[1][idx];
    pix_win[1][2] = pix_line[0][idx];
    pix_win[2][2] = pix;
    pix_line[1][idx] = pix_line[0][idx];
    pix_line[0][idx] = pix;
    if (r >= 2 && c >= 2) begin
      dx = 0;
      dy = 0;
      for (int i = 0; i < 3; i++) begin
        dx += int'(pix_win[i][2]) - int'(pix_win[i][0]);
        dy += int'(pix_win[2][i]) - int'(pix_win[0][i]);
      end
      m2 = dx * dx + dy * dy;
      if (m2 >= p_thr * p_thr) begin
        half = int_sqrt(m2) >> 1;
        g = (half > 255) ? 255 : half;
        a = grad_angle(dx, dy);
      end
    end
    // shift gradient window
    for (int i = 0; i < 3; i++) begin
      grad_win[i][0] = grad_win[i][1];
      grad_win[i][1] = grad_win[i][2];
    end
    grad_win[0][2] = grad_line[1][idx];
    grad_win[1][2] = grad_line[0][idx];
    grad_win[2][2] = g[7:0];
    grad_line[1][idx] = grad_line[0][idx];
    grad_line[0][idx] = g[7:0];
    old_a = ang_line[idx];
    ang_line[idx] = a[7:0];
    ca = ang_delay;
    ang_delay = old_a;
    // suppress along the gradient sector
    if (r >= 3 && c >= 3) begin
      gv = grad_win[1][1];
      res.edge_v = 0;
      if (!(r == 3 || c == 3 || r >= h || c >= w) && gv >= p_thr) begin
        if (ca <= 22 || ca >= 158) begin
          n0 = grad_win[1][2]; n1 = grad_win[1][0];
        end else if (ca <= 67) begin
          n0 = grad_win[2][0]; n1 = grad_win[0][2];
        end else if (ca <= 112) begin
          n0 = grad_win[2][1]; n1 = grad_win[0][1];
        end else begin
          n0 = grad_win[0][0]; n1 = grad_win[2][2];
        end
        if (gv >= n0 && gv >= n1) res.edge_v = gv[7:0];
      end
      res.half = gv[7:0];
      res.ang = ca[7:0];
      res.row = 10'(r - 3);
      res.col = 10'(c - 3);
      res.last = (r == h - 1 && c == w - 1);
      edge_q.push_back(res);
    end
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    pos_row = r & 10'h3FF;
    pos_col = c & 10'h3FF;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: present queued pixels, idle in random bursts
  int drv_gap;
  always @(posedge clk) begin
    pixel_req_t nxt;
    logic       v_next;
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      v_next = in_valid;
      if (in_valid && in_ready) begin
        predict_pixel(pixel, frame_start);
        pixels_sent++;
        v_next = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) drv_gap = $urandom_range(1, 10);
      end
      if (!v_next) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          pixel <= nxt.pix;
          frame_start <= nxt.fs;
          v_next = 1'b1;
        end
      end
      in_valid <= v_next;
    end
  end

  // Monitor: check edges against the oldest prediction, stall at random
  int mon_gap;
  int hold_cnt;
  always @(posedge clk) begin
    edge_res_t ex;
    if (rst) begin
      out_ready <= 1'b0;
      mon_gap = 0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        edges_seen++;
        if (edge_q.size() == 0) begin
          $display("%0t: unexpected edge result row %0d col %0d", $time, out_row, out_col);
          errors++;
        end else begin
          ex = edge_q.pop_front();
          if (edge_value !== ex.edge_v) begin
            $display("%0t: edge_value exp %0d got %0d", $time, ex.edge_v, edge_value);
            errors++;
          end
          if (gradient_half !== ex.half) begin
            $display("%0t: gradient_half exp %0d got %0d", $time, ex.half, gradient_half);
            errors++;
          end
          if (angle_deg !== ex.ang) begin
            $display("%0t: angle_deg exp %0d got %0d", $time, ex.ang, angle_deg);
            errors++;
          end
          if (out_row !== ex.row) begin
            $display("%0t: out_row exp %0d got %0d", $time, ex.row, out_row);
            errors++;
          end
          if (out_col !== ex.col) begin
            $display("%0t: out_col exp %0d got %0d", $time, ex.col, out_col);
            errors++;
          end
          if (frame_last !== ex.last) begin
            $display("%0t: frame_last exp %0d got %0d", $time, ex.last, frame_last);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        out_ready <= 1'b0;
      end else begin
        if (!quiet && $urandom_range(0, 5) == 0) mon_gap = $urandom_range(1, 10);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[10:0];
    if (idx == CFG_THRESHOLD) p_thr = val & 8'hFF;
    else if (idx == CFG_WIDTH) p_width = val & 11'h7FF;
    else if (idx == CFG_HEIGHT) p_height = val & 11'h7FF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued pixel is taken and every edge has come back
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid || edge_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Queue one frame; style picks the image content, cut ends it early
  task automatic queue_frame(input int w, input int h, input int style, input int cut);
    pixel_req_t pr;
    int         total;
    int         lvl;
    total = (cut > 0) ? cut : w * h;
    lvl = $urandom_range(0, 255);
    for (int i = 0; i < total; i++) begin
      pr.fs = (i == 0);
      case (style)
        0: pr.pix = $urandom_range(0, 255);
        1: pr.pix = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        2: pr.pix = 8'(((i % w) * 37 + (i / w) * 23 + lvl) & 8'hFF);
        default: pr.pix = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(lvl);
      endcase
      pixel_q.push_back(pr);
    end
  endtask

  // Stimulus
  initial begin
    pixel_req_t pr;
    int w, h;
    errors = 0;
    pixels_sent = 0;
    edges_seen = 0;
    phases_run = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = '0;
    frame_start = 1'b0;
    out_ready = 1'b0;
    build_tables();
    p_thr = THR_RESET;
    p_width = WIDTH_RESET;
    p_height = HEIGHT_RESET;
    pos_row = 0;
    pos_col = 0;
    ang_delay = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        pix_win[i][j] = 0;
        grad_win[i][j] = 0;
      end
    for (int i = 0; i < MAXW; i++) begin
      pix_line[0][i] = 0; pix_line[1][i] = 0;
      grad_line[0][i] = 0; grad_line[1][i] = 0;
      ang_line[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest frame, full-contrast step, zero threshold
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 5);
    write_reg(CFG_THRESHOLD, 0);
    for (int i = 0; i < 25; i++) begin
      pr.fs = (i == 0);
      pr.pix = ((i % 5) >= 2 || (i / 5) == 4) ? 8'd255 : 8'd0;
      pixel_q.push_back(pr);
    end
    wait_drained();
    phases_run++;

    // Random small frames under varied thresholds
    while (pixels_sent < 350) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_THRESHOLD, 255);
        1: write_reg(CFG_THRESHOLD, 0);
        default: write_reg(CFG_THRESHOLD, $urandom_range(1, 80));
      endcase
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 8);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      if (phases_run == 1) hold_req = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) queue_frame(w, h, $urandom_range(0, 3),
                                                   $urandom_range(1, w * h - 1));
        else queue_frame(w, h, $urandom_range(0, 3), 0);
      end
      wait_drained();
      phases_run++;
    end

    // Clamped widest and tallest sizes, one partial frame each
    write_reg(CFG_THRESHOLD, 20);
    write_reg(CFG_WIDTH, 2000);
    write_reg(CFG_HEIGHT, 5);
    queue_frame(1024, 5, 0, 40);
    wait_drained();
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 2000);
    queue_frame(5, 1024, 1, 60);
    wait_drained();
    phases_run += 2;

    // Closing phase at full rate
    quiet = 1'b1;
    write_reg(CFG_THRESHOLD, $urandom_range(10, 40));
    write_reg(CFG_WIDTH, 9);
    write_reg(CFG_HEIGHT, 6);
    queue_frame(9, 6, 0, 0);
    queue_frame(9, 6, 1, 0);
    wait_drained();
    phases_run++;

    $display("Ran %0d configuration phases: %0d pixels in, %0d edge results checked.",
             phases_run, pixels_sent, edges_seen);
    if (errors == 0) begin
      $display("prewitt_gradient_nms_unit_tb OK");
    end else begin
      $display("%0d mismatches found", errors);
      $display("prewitt_gradient_nms_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timed out with %0d edges outstanding", edge_q.size());
    $display("prewitt_gradient_nms_unit_tb NOT OK");
    $finish;
  end

endmodule
